### rtl/spdc_pkg.sv
// Shared types, character codes and conversion functions for the debug command parser.
`default_nettype none
package spdc_pkg;

  localparam int COMMAND_SLOTS_DEF = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_0 = 8'h30;
  localparam logic [7:0] CHAR_9 = 8'h39;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_UA = 8'h41;
  localparam logic [7:0] CHAR_UC = 8'h43;
  localparam logic [7:0] CHAR_UD = 8'h44;
  localparam logic [7:0] CHAR_UE = 8'h45;
  localparam logic [7:0] CHAR_UF = 8'h46;
  localparam logic [7:0] CHAR_UH = 8'h48;
  localparam logic [7:0] CHAR_UI = 8'h49;
  localparam logic [7:0] CHAR_UL = 8'h4C;
  localparam logic [7:0] CHAR_UO = 8'h4F;
  localparam logic [7:0] CHAR_UR = 8'h52;
  localparam logic [7:0] CHAR_UU = 8'h55;
  localparam logic [7:0] CHAR_UZ = 8'h5A;
  localparam logic [7:0] CHAR_LA = 8'h61;
  localparam logic [7:0] CHAR_LZ = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // One command request handed from the front end to the back end.
  typedef struct packed {
    logic [6:0]      op;
    logic [6:0]      sel;
    logic [6:0]      hi;
    logic [6:0]      lo;
    logic [3:0][7:0] pins;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_SEND
  } back_state_t;

  function automatic logic [3:0] hex_to_nib(input logic [6:0] c);
    logic [7:0] w;
    w = {1'b0, c};
    if (w >= CHAR_0 && w <= CHAR_9) begin
      return 4'(w - CHAR_0);
    end else if (w >= CHAR_UA && w <= CHAR_UF) begin
      return 4'(w - CHAR_UA + 8'd10);
    end
    return 4'd0;
  endfunction

  function automatic logic [7:0] nib_to_hex(input logic [3:0] n);
    if (n < 4'd10) begin
      return CHAR_0 + {4'd0, n};
    end
    return CHAR_UA + {4'd0, n} - 8'd10;
  endfunction

  function automatic logic [7:0] err_char(input logic [2:0] i);
    logic [7:0] c;
    unique case (i)
      3'd0: c = CHAR_UE;
      3'd1: c = CHAR_UR;
      3'd2: c = CHAR_UR;
      3'd3: c = CHAR_COLON;
      3'd4: c = CHAR_UU;
      3'd5: c = CHAR_UC;
      3'd6: c = CHAR_LF;
      default: c = CHAR_CR;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

### rtl/spdc_front.sv
// Front end: classifies received characters, keeps the command store and issues command requests.
`default_nettype none
module spdc_front #(
  parameter int CommandSlots = spdc_pkg::COMMAND_SLOTS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire logic [7:0]    rx_char,
  input  wire logic [7:0]    pin_a,
  input  wire logic [7:0]    pin_b,
  input  wire logic [7:0]    pin_c,
  input  wire logic [7:0]    pin_d,
  output logic               push,
  output spdc_pkg::cmd_t     cmd
);
  import spdc_pkg::*;

  localparam int CntW = $clog2(CommandSlots + 1);
  localparam int IdxW = $clog2(CommandSlots);

  logic [6:0]      store [CommandSlots];
  logic [CntW-1:0] fill_count;
  logic            is_eol;
  logic [7:0]      ch;
  logic            keep;

  always_comb begin
    is_eol = (rx_char == CHAR_LF) || (rx_char == CHAR_CR);
    ch = 8'd0;
    if (rx_char >= CHAR_LA && rx_char <= CHAR_LZ) begin
      ch = rx_char - CASE_OFFSET;
    end else if ((rx_char >= CHAR_0 && rx_char <= CHAR_9) ||
                 (rx_char >= CHAR_UA && rx_char <= CHAR_UZ)) begin
      ch = rx_char;
    end
    keep = (ch != 8'd0) && (fill_count < CntW'(CommandSlots));
    push = accept && is_eol && (fill_count != '0);
    cmd.op   = (fill_count > CntW'(0)) ? store[0] : 7'd0;
    cmd.sel  = (fill_count > CntW'(1)) ? store[1] : 7'd0;
    cmd.hi   = (fill_count > CntW'(2)) ? store[2] : 7'd0;
    cmd.lo   = (fill_count > CntW'(3)) ? store[3] : 7'd0;
    cmd.pins = {pin_d, pin_c, pin_b, pin_a};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (accept) begin
      if (is_eol) begin
        fill_count <= '0;
      end else if (keep) begin
        fill_count <= fill_count + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_eol && keep) begin
      store[fill_count[IdxW-1:0]] <= ch[6:0];
    end
  end

endmodule
`default_nettype wire

### rtl/spdc_queue.sv
// Short request queue between the front end and the back end.
`default_nettype none
module spdc_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr_en,
  input  wire spdc_pkg::cmd_t  wr_data,
  output logic                 full,
  input  wire logic            rd_en,
  output logic                 rd_valid,
  output spdc_pkg::cmd_t       rd_data
);
  import spdc_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            entries [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full     = (count == CntW'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CntW'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

### rtl/spdc_back.sv
// Back end: executes command requests, holds the port registers and sends the reply characters.
`default_nettype none
module spdc_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  input  wire spdc_pkg::cmd_t  q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [7:0]           reply_char,
  output logic                 reply_last
);
  import spdc_pkg::*;

  back_state_t state;
  back_state_t state_next;
  logic [7:0]  output_regs [4];
  logic [7:0]  direction_regs [4];
  logic [7:0]  reply_byte;
  logic        reply_err;
  logic [2:0]  char_idx;

  logic        out_accept;
  logic [7:0]  op;
  logic [7:0]  sel;
  logic [7:0]  sel_off;
  logic [1:0]  port;
  logic        sel_ad;
  logic        sel_eh;
  logic        sel_il;
  logic        is_read;
  logic        is_write;
  logic [7:0]  exec_byte;

  always_comb begin
    op       = {1'b0, q_data.op};
    sel      = {1'b0, q_data.sel};
    sel_off  = sel - CHAR_UA;
    port     = sel_off[1:0];
    sel_ad   = (sel >= CHAR_UA) && (sel <= CHAR_UD);
    sel_eh   = (sel >= CHAR_UE) && (sel <= CHAR_UH);
    sel_il   = (sel >= CHAR_UI) && (sel <= CHAR_UL);
    is_read  = (op == CHAR_UI);
    is_write = (op == CHAR_UO);
    exec_byte = 8'd0;
    if (is_read) begin
      if (sel_ad) begin
        exec_byte = q_data.pins[port];
      end else if (sel_eh) begin
        exec_byte = direction_regs[port];
      end else if (sel_il) begin
        exec_byte = output_regs[port];
      end
    end else if (is_write) begin
      exec_byte = {hex_to_nib(q_data.hi), hex_to_nib(q_data.lo)};
    end
  end

  always_comb begin
    out_valid  = (state == BK_SEND);
    out_accept = out_valid && !out_stall;
    if (reply_err) begin
      reply_char = err_char(char_idx);
      reply_last = (char_idx == 3'd7);
    end else begin
      unique case (char_idx[1:0])
        2'd0: reply_char = nib_to_hex(reply_byte[7:4]);
        2'd1: reply_char = nib_to_hex(reply_byte[3:0]);
        2'd2: reply_char = CHAR_LF;
        default: reply_char = CHAR_CR;
      endcase
      reply_last = (char_idx[1:0] == 2'd3);
    end
    q_pop      = 1'b0;
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = BK_SEND;
        end
      end
      BK_SEND: begin
        if (out_accept && reply_last) begin
          q_pop      = q_valid;
          state_next = q_valid ? BK_SEND : BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_idx <= 3'd0;
      for (int i = 0; i < 4; i++) begin
        output_regs[i]    <= 8'd0;
        direction_regs[i] <= 8'd0;
      end
    end else if (q_pop) begin
      char_idx <= 3'd0;
      if (is_write && sel_ad) begin
        output_regs[port] <= exec_byte;
      end else if (is_write && sel_eh) begin
        direction_regs[port] <= exec_byte;
      end
    end else if (out_accept) begin
      char_idx <= char_idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      reply_byte <= exec_byte;
      reply_err  <= !(is_read || is_write);
    end
  end

endmodule
`default_nettype wire

### rtl/serial_port_debug_command_parser_core.sv
// Top level of the serial debug command parser: front end, request queue and back end.
//
// The input channel carries one received character together with the sampled levels of
// ports A to D. Letters and digits build a command; CR or LF runs it, using the pin levels
// sampled with that line ending. The output channel carries the reply one character at a
// time, with reply_last on its final character.
// An input request is taken in every cycle while the request queue has room; ordinary
// characters produce no reply. A line ending that runs a command enters the queue; the
// back end pops it once free and registers its send state, from which the first reply
// character is offered. The back end sends one character per cycle unless the receiver
// stalls: a read or write reply has four characters and an error reply eight, counted by
// the character counter. Two commands may wait in the queue while a reply is being sent.
// When the receiver stalls, the current reply character holds and the queue fills; once it
// is full the input channel is stalled in turn.
// Reset empties the command store and the queue and clears all output and direction
// registers; no character is offered until a command has been run.
`default_nettype none
module serial_port_debug_command_parser_core #(
  parameter int CommandSlots = spdc_pkg::COMMAND_SLOTS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_char,
  input  wire logic [7:0] pin_a,
  input  wire logic [7:0] pin_b,
  input  wire logic [7:0] pin_c,
  input  wire logic [7:0] pin_d,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      reply_char,
  output logic            reply_last
);
  import spdc_pkg::*;

  logic  in_accept;
  logic  push;
  cmd_t  front_cmd;
  logic  q_full;
  logic  q_valid;
  logic  q_pop;
  cmd_t  q_data;

  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  spdc_front #(
    .CommandSlots(CommandSlots)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (in_accept),
    .rx_char (rx_char),
    .pin_a   (pin_a),
    .pin_b   (pin_b),
    .pin_c   (pin_c),
    .pin_d   (pin_d),
    .push    (push),
    .cmd     (front_cmd)
  );

  spdc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (push),
    .wr_data  (front_cmd),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_data)
  );

  spdc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .reply_char (reply_char),
    .reply_last (reply_last)
  );

endmodule
`default_nettype wire

### bench/tb_top.sv
// Self-checking bench for the serial debug command parser: a directed table, then random requests.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spdc_pkg::*;

  localparam int SLOTS = COMMAND_SLOTS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 94;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 16;

  typedef struct {
    logic [7:0]      rx;
    logic [3:0][7:0] pins;
    bit              typed;
    string           reply;
  } row_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } reply_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] rx_char;
  logic [7:0] pin_a;
  logic [7:0] pin_b;
  logic [7:0] pin_c;
  logic [7:0] pin_d;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] reply_char;
  logic       reply_last;

  serial_port_debug_command_parser_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_char    (rx_char),
    .pin_a      (pin_a),
    .pin_b      (pin_b),
    .pin_c      (pin_c),
    .pin_d      (pin_d),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .reply_char (reply_char),
    .reply_last (reply_last)
  );

  logic [6:0] cmd_store [SLOTS];
  int         cmd_fill = 0;
  logic [7:0] port_out [4];
  logic [7:0] port_dir [4];
  reply_t     reply_due [$];
  row_t       script [$];
  int         mismatches = 0;
  int         cycle_count = 0;
  bit         gaps_on = 1'b1;
  bit         hold_off_req = 1'b0;

  function automatic logic [7:0] nibble_char(input logic [3:0] n);
    if (n < 4'd10) begin
      return CHAR_0 + 8'(n);
    end
    return CHAR_UA + 8'(n) - 8'd10;
  endfunction

  function automatic logic [3:0] char_nibble(input logic [7:0] c);
    if (c >= CHAR_0 && c <= CHAR_9) begin
      return 4'(c - CHAR_0);
    end
    if (c >= CHAR_UA && c <= CHAR_UF) begin
      return 4'(c - CHAR_UA + 8'd10);
    end
    return 4'd0;
  endfunction

  function automatic logic [7:0] stored(input int i);
    return (i < cmd_fill) ? {1'b0, cmd_store[i]} : 8'h00;
  endfunction

  function automatic logic [7:0] any_case(input logic [7:0] c);
    if (c >= CHAR_UA && c <= CHAR_UZ && $urandom_range(0, 1) == 1) begin
      return c + CASE_OFFSET;
    end
    return c;
  endfunction

  // Updates the command store and port registers for one request and returns the reply text.
  function automatic string predict_reply(input logic [7:0] c, input logic [3:0][7:0] pins);
    string      s;
    logic [7:0] op;
    logic [7:0] sel;
    logic [7:0] ch;
    logic [7:0] val;
    s = "";
    if (c == CHAR_LF || c == CHAR_CR) begin
      if (cmd_fill > 0) begin
        op = stored(0);
        sel = stored(1);
        val = 8'h00;
        if (op == CHAR_UI) begin
          if (sel >= CHAR_UA && sel <= CHAR_UD) begin
            val = pins[sel - CHAR_UA];
          end else if (sel >= CHAR_UE && sel <= CHAR_UH) begin
            val = port_dir[sel - CHAR_UE];
          end else if (sel >= CHAR_UI && sel <= CHAR_UL) begin
            val = port_out[sel - CHAR_UI];
          end
        end else if (op == CHAR_UO) begin
          val = {char_nibble(stored(2)), char_nibble(stored(3))};
          if (sel >= CHAR_UA && sel <= CHAR_UD) begin
            port_out[sel - CHAR_UA] = val;
          end else if (sel >= CHAR_UE && sel <= CHAR_UH) begin
            port_dir[sel - CHAR_UE] = val;
          end
        end
        if (op == CHAR_UI || op == CHAR_UO) begin
          s = "00\012\015";
          s.putc(0, nibble_char(val[7:4]));
          s.putc(1, nibble_char(val[3:0]));
        end else begin
          s = "ERR:UC\012\015";
        end
      end
      cmd_fill = 0;
      for (int i = 0; i < SLOTS; i++) begin
        cmd_store[i] = '0;
      end
    end else begin
      ch = 8'h00;
      if (c >= CHAR_LA && c <= CHAR_LZ) begin
        ch = c - CASE_OFFSET;
      end else if ((c >= CHAR_0 && c <= CHAR_9) || (c >= CHAR_UA && c <= CHAR_UZ)) begin
        ch = c;
      end
      if (ch != 8'h00 && cmd_fill < SLOTS) begin
        cmd_store[cmd_fill] = ch[6:0];
        cmd_fill++;
      end
    end
    return s;
  endfunction

  function automatic void queue_reply(input string s);
    for (int k = 0; k < s.len(); k++) begin
      reply_due.push_back('{ch: s[k], last: (k == s.len() - 1)});
    end
  endfunction

  task automatic add_row(input logic [7:0] c, input logic [31:0] pins, input bit typed,
                         input string reply);
    row_t r;
    r.rx = c;
    r.pins = pins;
    r.typed = typed;
    r.reply = reply;
    script.push_back(r);
  endtask

  task automatic offer_request(input logic [7:0] c, input logic [3:0][7:0] pins,
                               input bit typed, input string typed_reply);
    string predicted;
    @(negedge clk);
    while (gaps_on && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_char <= c;
    pin_a <= pins[0];
    pin_b <= pins[1];
    pin_c <= pins[2];
    pin_d <= pins[3];
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    predicted = predict_reply(c, pins);
    queue_reply(typed ? typed_reply : predicted);
  endtask

  // Sends one random line and reports how many requests it sent.
  task automatic send_line(output int counted);
    logic [7:0] line [$];
    int         kind;
    logic [7:0] op;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: begin
        line.push_back(any_case(CHAR_UI));
        if ($urandom_range(0, 7) != 0) begin
          line.push_back(any_case(($urandom_range(0, 5) == 0) ?
                                  CHAR_UA + 8'($urandom_range(0, 25)) :
                                  CHAR_UA + 8'($urandom_range(0, 11))));
        end
        if ($urandom_range(0, 5) == 0) begin
          line.push_back(CHAR_0 + 8'($urandom_range(0, 9)));
        end
      end
      4, 5, 6: begin
        line.push_back(any_case(CHAR_UO));
        line.push_back(any_case(($urandom_range(0, 5) == 0) ?
                                CHAR_UA + 8'($urandom_range(0, 25)) :
                                CHAR_UA + 8'($urandom_range(0, 7))));
        repeat ($urandom_range(0, 7) == 0 ? 1 : 2) begin
          line.push_back(($urandom_range(0, 7) == 0) ?
                         CHAR_UA + 8'($urandom_range(6, 25)) :
                         any_case(nibble_char(4'($urandom_range(0, 15)))));
        end
      end
      7: begin
        op = ($urandom_range(0, 1) == 1) ? CHAR_0 + 8'($urandom_range(0, 9)) :
                                           CHAR_UA + 8'($urandom_range(0, 25));
        if (op == CHAR_UI || op == CHAR_UO) begin
          op = CHAR_UZ;
        end
        line.push_back(any_case(op));
        repeat ($urandom_range(0, 3)) begin
          line.push_back(any_case(CHAR_UA + 8'($urandom_range(0, 25))));
        end
      end
      8: begin
        repeat ($urandom_range(1, 4)) begin
          line.push_back(8'($urandom_range(0, 255)));
        end
      end
      default: begin
        repeat ($urandom_range(5, 8)) begin
          line.push_back(($urandom_range(0, 3) == 0) ? CHAR_0 + 8'($urandom_range(0, 9)) :
                         any_case(CHAR_UA + 8'($urandom_range(0, 25))));
        end
      end
    endcase
    if ($urandom_range(0, 9) == 0) begin
      line.insert($urandom_range(0, line.size()), 8'($urandom_range(0, 255)));
    end
    line.push_back(($urandom_range(0, 1) == 1) ? CHAR_CR : CHAR_LF);
    if ($urandom_range(0, 9) == 0) begin
      line.push_back(CHAR_CR);
    end
    foreach (line[i]) begin
      offer_request(line[i], 32'($urandom), 1'b0, "");
    end
    counted = line.size();
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        for (int k = 1; k < HOLD_CYCLES; k++) begin
          @(negedge clk);
        end
        hold_off_req = 1'b0;
      end else begin
        out_stall <= gaps_on && ($urandom_range(0, 99) < 16);
      end
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (!rst && out_valid && !out_stall) begin
      if (reply_due.size() == 0) begin
        $error("reply_char: expected nothing, actual 0x%02h", reply_char);
        mismatches++;
      end else begin
        want = reply_due.pop_front();
        if (reply_char !== want.ch) begin
          $error("reply_char: expected 0x%02h, actual 0x%02h", want.ch, reply_char);
          mismatches++;
        end
        if (reply_last !== want.last) begin
          $error("reply_last: expected %0b, actual %0b", want.last, reply_last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int sent;
    int got;
    bit hold_started;
    rst = 1'b1;
    in_valid = 1'b0;
    rx_char = 8'h00;
    pin_a = 8'h00;
    pin_b = 8'h00;
    pin_c = 8'h00;
    pin_d = 8'h00;
    hold_started = 1'b0;
    for (int i = 0; i < 4; i++) begin
      port_out[i] = 8'h00;
      port_dir[i] = 8'h00;
    end
    for (int i = 0; i < SLOTS; i++) begin
      cmd_store[i] = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Lower-case read of a direction register straight after reset.
    add_row(8'h69, 32'h0, 1'b0, "");
    add_row(8'h65, 32'h0, 1'b0, "");
    add_row(CHAR_CR, 32'h0, 1'b1, "00\012\015");
    add_row(CHAR_UI, 32'h0, 1'b0, "");
    add_row(CHAR_UA, 32'h0, 1'b0, "");
    add_row(CHAR_LF, 32'h0000_00FF, 1'b1, "FF\012\015");
    // An empty command gives no reply.
    add_row(CHAR_CR, 32'hFFFF_FFFF, 1'b1, "");
    // A fifth character is dropped once the store is full.
    add_row(8'h6F, 32'h0, 1'b0, "");
    add_row(8'h68, 32'h0, 1'b0, "");
    add_row(8'h66, 32'h0, 1'b0, "");
    add_row(8'h66, 32'h0, 1'b0, "");
    add_row(8'h7A, 32'h0, 1'b0, "");
    add_row(CHAR_CR, 32'h0, 1'b1, "FF\012\015");
    add_row(CHAR_UI, 32'h0, 1'b0, "");
    add_row(CHAR_UH, 32'h0, 1'b0, "");
    add_row(CHAR_LF, 32'h0, 1'b0, "");
    // Unknown write selector with a missing low digit.
    add_row(CHAR_UO, 32'h0, 1'b0, "");
    add_row(CHAR_UZ, 32'h0, 1'b0, "");
    add_row(CHAR_0 + 8'd1, 32'h0, 1'b0, "");
    add_row(CHAR_CR, 32'h0, 1'b0, "");
    add_row(8'hFF, 32'h0, 1'b0, "");
    add_row(8'h00, 32'h0, 1'b0, "");
    add_row(8'h58, 32'h0, 1'b0, "");
    add_row(CHAR_CR, 32'h0, 1'b1, "ERR:UC\012\015");
    // A read with no selector.
    add_row(CHAR_UI, 32'hFFFF_FFFF, 1'b0, "");
    add_row(CHAR_CR, 32'hFFFF_FFFF, 1'b1, "00\012\015");

    foreach (script[i]) begin
      offer_request(script[i].rx, script[i].pins, script[i].typed, script[i].reply);
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= 30 && !hold_started) begin
        hold_off_req = 1'b1;
        hold_started = 1'b1;
      end
      gaps_on = !(sent >= 60 && sent < 90);
      send_line(got);
      sent += got;
    end
    gaps_on = 1'b1;
    @(negedge clk);
    in_valid <= 1'b0;

    while (reply_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
